// ----- hdl/sfc_pkg.sv -----
// sfc_pkg: shared constants, action codes, word types and state encoding
// for the streaming fir convolver
// no dependencies

package sfc_pkg;

    localparam int SFC_SAMPLE_BITS    = 16;
    localparam int SFC_INDEX_BITS     = 8;
    localparam int SFC_ACTION_BITS    = 2;
    localparam int SFC_TAP_COUNT_BITS = 9;
    localparam int SFC_MAX_TAPS       = 256;

    localparam logic [SFC_ACTION_BITS-1:0] ACT_LOAD  = 2'd0;
    localparam logic [SFC_ACTION_BITS-1:0] ACT_PUSH  = 2'd1;
    localparam logic [SFC_ACTION_BITS-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [SFC_ACTION_BITS-1:0]        action;
        logic [SFC_INDEX_BITS-1:0]         coef_index;
        logic signed [SFC_SAMPLE_BITS-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [SFC_SAMPLE_BITS-1:0] filtered_sample;
        logic                              saturated;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic data_vld;
        logic round;
    } t_mac_ctrl;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_ROUND,
        ST_FINISH
    } t_state;

endpackage

// ----- hdl/sfc_ram.sv -----
// sfc_ram: generic single write port, single read port ram with registered read
// no dependencies

module sfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sfc_mac.sv -----
// sfc_mac: shared multiply-accumulate unit with rounding and saturation
// depends on sfc_pkg

module sfc_mac #(
    parameter int ACC_W = 40
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  sfc_pkg::t_mac_ctrl                         i_ctrl,
    input  logic signed [sfc_pkg::SFC_SAMPLE_BITS-1:0] i_coef,
    input  logic signed [sfc_pkg::SFC_SAMPLE_BITS-1:0] i_sample,
    output logic                                       o_busy,
    output sfc_pkg::t_out_word                         o_result
);

    import sfc_pkg::*;

    localparam int SB = SFC_SAMPLE_BITS;
    localparam int QW = ACC_W - (SB - 1);

    logic signed [2*SB-1:0]  r_prod;
    logic                    r_prod_vld;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic [QW-1:0]           w_q;
    logic [QW-SB:0]          w_upper;
    logic                    w_sat;

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.round) begin
            n_acc = r_acc + (ACC_W'(1) << (SB - 2));
        end else if (r_prod_vld) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.data_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_sample;
        r_acc  <= n_acc;
    end

    // arithmetic shift right by the fraction width, then range check
    assign w_q     = r_acc[ACC_W-1:SB-1];
    assign w_upper = w_q[QW-1:SB-1];
    assign w_sat   = !((&w_upper) || (~|w_upper));

    always_comb begin
        o_result.saturated = w_sat;
        if (!w_sat) begin
            o_result.filtered_sample = w_q[SB-1:0];
        end else if (w_q[QW-1]) begin
            o_result.filtered_sample = {1'b1, {(SB-1){1'b0}}};
        end else begin
            o_result.filtered_sample = {1'b0, {(SB-1){1'b1}}};
        end
    end

    assign o_busy = r_prod_vld;

endmodule

// ----- hdl/streaming_fir_convolver.sv -----
// streaming_fir_convolver: direct-form fir filter over a circular sample history
// push word: one tap per cycle through the one shared multiply-accumulate unit,
// taps = min(tap_count, MAX_TAPS); then drain and round; zero taps pass the sample through
// load word: written on accept; clear word: history clearing pass
// reset: synchronous, active low; then a pass clears both rams,
// no input word accepted meanwhile; depends on sfc_pkg, sfc_ram, sfc_mac

module streaming_fir_convolver #(
    parameter int MAX_TAPS = sfc_pkg::SFC_MAX_TAPS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [sfc_pkg::SFC_TAP_COUNT_BITS-1:0]    i_cfg_wdata,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  sfc_pkg::t_in_word                         i_in_word,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output sfc_pkg::t_out_word                        o_out_word
);

    import sfc_pkg::*;

    localparam int SB      = SFC_SAMPLE_BITS;
    localparam int AW      = $clog2(MAX_TAPS);
    localparam int TW      = $clog2(MAX_TAPS + 1);
    localparam int ACC_RAW = 2 * SB + AW;
    localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    t_state                        r_state;
    t_state                        n_state;
    logic [SFC_TAP_COUNT_BITS-1:0] r_tap_count;
    logic [AW-1:0]                 r_clr_addr;
    logic [AW-1:0]                 n_clr_addr;
    logic                          r_clr_coef;
    logic                          n_clr_coef;
    logic [AW-1:0]                 r_ptr;
    logic [AW-1:0]                 n_ptr;
    logic [AW-1:0]                 r_hist_addr;
    logic [AW-1:0]                 n_hist_addr;
    logic [AW-1:0]                 r_k;
    logic [AW-1:0]                 n_k;
    logic [TW-1:0]                 r_taps;
    logic [TW-1:0]                 n_taps;
    logic                          r_pass;
    logic                          n_pass;
    logic signed [SB-1:0]          r_sample;
    logic signed [SB-1:0]          n_sample;
    logic                          r_rd_vld;
    logic                          r_out_valid;
    t_out_word                     r_out_word;

    logic                          w_accept;
    logic [AW-1:0]                 w_ptr_inc;
    logic [TW-1:0]                 w_taps;
    logic                          w_last_k;
    logic                          w_in_ready;
    logic                          w_out_load;
    logic                          w_coef_we;
    logic [AW-1:0]                 w_coef_waddr;
    logic [SB-1:0]                 w_coef_wdata;
    logic                          w_hist_we;
    logic [AW-1:0]                 w_hist_waddr;
    logic [SB-1:0]                 w_hist_wdata;
    logic [SB-1:0]                 w_coef_rdata;
    logic [SB-1:0]                 w_hist_rdata;
    t_mac_ctrl                     w_mac_ctrl;
    logic                          w_mac_busy;
    t_out_word                     w_mac_result;

    assign w_accept  = i_in_valid && w_in_ready;
    assign w_ptr_inc = (r_ptr == LAST_ADDR) ? '0 : r_ptr + AW'(1);
    assign w_taps    = (int'(r_tap_count) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(r_tap_count);
    assign w_last_k  = (TW'(r_k) == r_taps - TW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_word.action)
                        ACT_PUSH:  n_state = (w_taps == '0) ? ST_FINISH : ST_ISSUE;
                        ACT_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ISSUE: begin
                if (w_last_k) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !w_mac_busy) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_in_ready          = 1'b0;
        w_out_load          = 1'b0;
        w_coef_we           = 1'b0;
        w_coef_waddr        = r_clr_addr;
        w_coef_wdata        = '0;
        w_hist_we           = 1'b0;
        w_hist_waddr        = r_clr_addr;
        w_hist_wdata        = '0;
        w_mac_ctrl.clear    = 1'b0;
        w_mac_ctrl.round    = 1'b0;
        w_mac_ctrl.data_vld = r_rd_vld;
        case (r_state)
            ST_CLEAR: begin
                w_hist_we = 1'b1;
                w_coef_we = r_clr_coef;
            end
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_word.action)
                        ACT_LOAD: begin
                            w_coef_we    = (int'(i_in_word.coef_index) < MAX_TAPS);
                            w_coef_waddr = AW'(i_in_word.coef_index);
                            w_coef_wdata = i_in_word.value;
                        end
                        ACT_PUSH: begin
                            w_hist_we        = 1'b1;
                            w_hist_waddr     = w_ptr_inc;
                            w_hist_wdata     = i_in_word.value;
                            w_mac_ctrl.clear = 1'b1;
                        end
                        default: begin
                            w_hist_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_ROUND: begin
                w_mac_ctrl.round = 1'b1;
            end
            ST_FINISH: begin
                w_out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        n_clr_addr  = r_clr_addr;
        n_clr_coef  = r_clr_coef;
        n_ptr       = r_ptr;
        n_hist_addr = r_hist_addr;
        n_k         = r_k;
        n_taps      = r_taps;
        n_pass      = r_pass;
        n_sample    = r_sample;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_clr_addr = '0;
                    n_clr_coef = 1'b0;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_word.action)
                        ACT_PUSH: begin
                            n_ptr       = w_ptr_inc;
                            n_hist_addr = w_ptr_inc;
                            n_k         = '0;
                            n_taps      = w_taps;
                            n_pass      = (w_taps == '0);
                            n_sample    = i_in_word.value;
                        end
                        ACT_CLEAR: begin
                            n_ptr      = '0;
                            n_clr_addr = '0;
                        end
                        default: begin
                            n_ptr = r_ptr;
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                n_k         = r_k + AW'(1);
                n_hist_addr = (r_hist_addr == '0) ? LAST_ADDR : r_hist_addr - AW'(1);
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_tap_count <= '0;
            r_clr_addr  <= '0;
            r_clr_coef  <= 1'b1;
            r_ptr       <= '0;
            r_hist_addr <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_coef  <= n_clr_coef;
            r_ptr       <= n_ptr;
            r_hist_addr <= n_hist_addr;
            r_rd_vld    <= (r_state == ST_ISSUE);
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_taps      <= n_taps;
        r_pass      <= n_pass;
        r_sample    <= n_sample;
        if (w_out_load) begin
            if (r_pass) begin
                r_out_word.filtered_sample <= r_sample;
                r_out_word.saturated       <= 1'b0;
            end else begin
                r_out_word <= w_mac_result;
            end
        end
    end

    sfc_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_waddr),
        .i_wdata (w_coef_wdata),
        .i_raddr (r_k),
        .o_rdata (w_coef_rdata)
    );

    sfc_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wdata),
        .i_raddr (r_hist_addr),
        .o_rdata (w_hist_rdata)
    );

    sfc_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mac_ctrl),
        .i_coef   (w_coef_rdata),
        .i_sample (w_hist_rdata),
        .o_busy   (w_mac_busy),
        .o_result (w_mac_result)
    );

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (TW'(r_k) < r_taps))
        else $error("tap counter ran past tap count");

    a_ready_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> (!r_rd_vld && !w_mac_busy))
        else $error("ready while mac pipeline busy");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("result word raised outside finish");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr <= LAST_ADDR) && (r_hist_addr <= LAST_ADDR))
        else $error("history pointer out of range");

endmodule

// ----- tb/fir_scoreboard_pkg.sv -----
// fir_scoreboard_pkg: output scoreboard for the streaming fir convolver test,
// keeps its own taps, sample history and queue of expected output words
// depends on sfc_pkg

package fir_scoreboard_pkg;

    import sfc_pkg::*;

    localparam logic [SFC_ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

    localparam longint OUT_MAX = (longint'(1) <<< (SFC_SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;
    localparam longint ROUND_HALF = longint'(1) <<< (SFC_SAMPLE_BITS - 2);

    class fir_output_scoreboard;

        logic signed [SFC_SAMPLE_BITS-1:0] history [SFC_MAX_TAPS];
        logic signed [SFC_SAMPLE_BITS-1:0] coefs [SFC_MAX_TAPS];
        logic [SFC_INDEX_BITS-1:0]         newest;
        logic [SFC_TAP_COUNT_BITS-1:0]     taps;
        t_out_word                         expected_outputs [$];
        int                                mismatches;

        function new();
            foreach (history[i]) begin
                history[i] = '0;
                coefs[i]   = '0;
            end
            newest     = '0;
            taps       = '0;
            mismatches = 0;
        endfunction

        function void set_taps(logic [SFC_TAP_COUNT_BITS-1:0] count);
            taps = count;
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // track one accepted input word; a push word queues the filtered sample it produces
        function void note_word(t_in_word w);
            int unsigned               used;
            logic [SFC_INDEX_BITS-1:0] p;
            longint                    acc;
            t_out_word                 y;
            case (w.action)
                ACT_LOAD: begin
                    coefs[w.coef_index] = w.value;
                end
                ACT_CLEAR: begin
                    foreach (history[i]) history[i] = '0;
                    newest = '0;
                end
                ACT_PUSH: begin
                    newest          = newest + 1'b1;
                    history[newest] = w.value;
                    used            = (taps > SFC_MAX_TAPS) ? SFC_MAX_TAPS : taps;
                    y.saturated     = 1'b0;
                    if (used == 0) begin
                        y.filtered_sample = w.value;
                    end else begin
                        acc = 0;
                        p   = newest;
                        for (int k = 0; k < used; k++) begin
                            acc += longint'(coefs[k]) * longint'(history[p]);
                            p = p - 1'b1;
                        end
                        acc = (acc + ROUND_HALF) >>> (SFC_SAMPLE_BITS - 1);
                        if (acc > OUT_MAX) begin
                            acc         = OUT_MAX;
                            y.saturated = 1'b1;
                        end else if (acc < OUT_MIN) begin
                            acc         = OUT_MIN;
                            y.saturated = 1'b1;
                        end
                        y.filtered_sample = acc[SFC_SAMPLE_BITS-1:0];
                    end
                    expected_outputs.push_back(y);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (expected_outputs.size() == 0) begin
                report($sformatf("output word with none expected: sample %0d sat %0b",
                                 got.filtered_sample, got.saturated));
                return;
            end
            want = expected_outputs.pop_front();
            if (got.filtered_sample !== want.filtered_sample ||
                got.saturated !== want.saturated) begin
                report($sformatf("mismatch: expected sample %0d sat %0b, got sample %0d sat %0b",
                                 want.filtered_sample, want.saturated,
                                 got.filtered_sample, got.saturated));
            end
        endfunction

    endclass

endpackage

// ----- tb/streaming_fir_convolver_test.sv -----
// streaming_fir_convolver_test: directed and random words through the fir convolver
// over several tap counts, with random stalls on both sides and one long output hold
// depends on sfc_pkg, fir_scoreboard_pkg and the streaming_fir_convolver rtl

module streaming_fir_convolver_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;
    import fir_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = SFC_MAX_TAPS + 40;
    localparam int HOLD_CYCLES    = 800;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [SFC_TAP_COUNT_BITS-1:0] i_cfg_wdata = '0;
    logic                          i_in_valid  = 1'b0;
    t_in_word                      i_in_word   = '0;
    logic                          i_out_ready = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    t_out_word                     o_out_word;

    fir_output_scoreboard outputs_sb;
    bit in_steady    = 1'b0;
    bit out_steady   = 1'b0;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;

    streaming_fir_convolver DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // output side: random stalls, or one long hold when asked
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= out_steady || ($urandom_range(99) >= 25);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            outputs_sb.check_word(o_out_word);
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            outputs_sb.note_word(i_in_word);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_word make_word(logic [SFC_ACTION_BITS-1:0] act,
                                           logic [SFC_INDEX_BITS-1:0] idx,
                                           logic signed [SFC_SAMPLE_BITS-1:0] v);
        t_in_word w;
        w.action     = act;
        w.coef_index = idx;
        w.value      = v;
        return w;
    endfunction

    function automatic t_in_word random_word(int unsigned taps);
        t_in_word    w;
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(99);
        span = (taps == 0) ? 1 : ((taps > SFC_MAX_TAPS) ? SFC_MAX_TAPS : taps);
        if (roll < 30) begin
            w.action = ACT_LOAD;
        end else if (roll < 94) begin
            w.action = ACT_PUSH;
        end else if (roll < 97) begin
            w.action = ACT_CLEAR;
        end else begin
            w.action = ACT_UNUSED;
        end
        if (w.action == ACT_LOAD && $urandom_range(1) == 0) begin
            w.coef_index = SFC_INDEX_BITS'($urandom_range(span - 1));
        end else begin
            w.coef_index = SFC_INDEX_BITS'($urandom);
        end
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: w.value = 16'sh7FFF;
                    1: w.value = 16'sh8000;
                    2: w.value = 16'sh0000;
                    default: w.value = 16'shFFFF;
                endcase
            end
            1: w.value = SFC_SAMPLE_BITS'($urandom_range(511)) - 16'sd256;
            default: w.value = SFC_SAMPLE_BITS'($urandom);
        endcase
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        while (!in_steady && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // drain all expected words, then let loads and clears finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outputs_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tap_count(input logic [SFC_TAP_COUNT_BITS-1:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        outputs_sb.set_taps(count);
    endtask

    task automatic run_directed();
        // pass-through at the reset tap count
        send_word(make_word(ACT_PUSH, 8'h00, 16'sh7FFF));
        send_word(make_word(ACT_PUSH, 8'hFF, 16'sh8000));
        send_word(make_word(ACT_PUSH, 8'h00, 16'sh0001));
        send_word(make_word(ACT_LOAD, 8'hFF, 16'sh8000));
        send_word(make_word(ACT_UNUSED, 8'h5A, 16'sh1234));
        send_word(make_word(ACT_LOAD, 8'h00, 16'sh3039));
        settle();
        write_tap_count(9'd2);
        // saturation both ways
        send_word(make_word(ACT_LOAD, 8'h00, 16'sh8000));
        send_word(make_word(ACT_LOAD, 8'h01, 16'sh8000));
        send_word(make_word(ACT_PUSH, 8'h00, 16'sh8000));
        send_word(make_word(ACT_PUSH, 8'h00, 16'sh8000));
        send_word(make_word(ACT_PUSH, 8'h00, 16'sh7FFF));
        send_word(make_word(ACT_PUSH, 8'h00, 16'sh7FFF));
        // clear empties the sample history
        send_word(make_word(ACT_CLEAR, 8'hFF, 16'shFFFF));
        send_word(make_word(ACT_PUSH, 8'h00, 16'sh0000));
        // halves round up
        send_word(make_word(ACT_LOAD, 8'h00, 16'sh0001));
        send_word(make_word(ACT_LOAD, 8'h01, 16'sh0000));
        send_word(make_word(ACT_PUSH, 8'h00, 16'sh4000));
        send_word(make_word(ACT_PUSH, 8'h00, 16'shC000));
        send_word(make_word(ACT_UNUSED, 8'hA5, 16'shFFFF));
        send_word(make_word(ACT_LOAD, 8'hFF, 16'sh7FFF));
        send_word(make_word(ACT_PUSH, 8'hFF, 16'sh0000));
    endtask

    task automatic run_phase(input int unsigned taps, input int count,
                             input bit steady, input bit hold);
        settle();
        write_tap_count(SFC_TAP_COUNT_BITS'(taps));
        in_steady  = steady;
        out_steady = steady;
        if (hold) begin
            hold_request = 1'b1;
        end
        repeat (count) send_word(random_word(taps));
    endtask

    initial begin
        outputs_sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_phase(1, 250, 1'b0, 1'b0);
        run_phase(3, 250, 1'b0, 1'b0);
        run_phase(16, 300, 1'b1, 1'b0);
        run_phase(256, 60, 1'b0, 1'b0);
        run_phase(0, 150, 1'b0, 1'b0);
        run_phase(8, 300, 1'b0, 1'b1);
        run_phase(511, 30, 1'b0, 1'b0);
        run_phase(40, 200, 1'b0, 1'b0);
        run_phase(255, 40, 1'b0, 1'b0);
        run_phase(2, 300, 1'b0, 1'b0);
        settle();
        if (outputs_sb.mismatches == 0 && outputs_sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
